FILE: sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants and helpers for the serial-set thermostat.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int LINE_MAX = 16;
    localparam int CNT_W    = $clog2(LINE_MAX);

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] MSG_NONE       = 2'd0;
    localparam logic [1:0] MSG_PROMPT_MIN = 2'd1;
    localparam logic [1:0] MSG_PROMPT_MAX = 2'd2;
    localparam logic [1:0] MSG_BAD_CMD    = 2'd3;

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [15:0] LOW_LIMIT_INIT  = 16'd25;
    localparam logic [15:0] HIGH_LIMIT_INIT = 16'd26;
    localparam logic [15:0] MAG_MAX         = 16'd32768;
    localparam logic [9:0]  FRAC_STEP       = 10'd625;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic signed [15:0] limit_t;

    // command spelling: "min" and "max"
    function automatic logic [7:0] cmd_min_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h6D;
            2'd1:    ch = 8'h69;
            2'd2:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] cmd_max_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h6D;
            2'd1:    ch = 8'h61;
            2'd2:    ch = 8'h78;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: sv/serial_set_thermostat.sv
// ----------------------------------------------------------------------------
// serial_set_thermostat
// Thermostat with limits set over a serial text link and raw sensor readings.
// ----------------------------------------------------------------------------
// Each input beat is either a serial byte or a raw 16-bit sensor word. A line
// beginning "min" or "max" ended by CR or LF selects a limit and returns a
// prompt code, any other line a bad-command code; the following line is read
// as a decimal integer (atoi style, clamped to 16 bits signed) and stored into
// that limit. Readings update the displayed temperature and switch the heater
// off at or above the upper limit and on below the lower limit. One beat is
// accepted every cycle unless the output holds a result that is not taken;
// its result appears in the output register in the next cycle, and a new beat
// is taken while it waits if the output side is ready in that same cycle.
module serial_set_thermostat
    import sst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] raw_reading,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  message,
    output logic        heater_on,
    output logic [7:0]  whole_degrees,
    output logic [13:0] fraction_digits,
    output logic [15:0] low_limit_now,
    output logic [15:0] high_limit_now
);

    count_t      char_count_reg, char_count_next;
    logic        starts_min_reg, starts_min_next;
    logic        starts_max_reg, starts_max_next;
    logic        value_stage_reg, value_stage_next;
    logic        target_high_reg, target_high_next;
    logic [1:0]  parse_phase_reg, parse_phase_next;
    logic        is_negative_reg, is_negative_next;
    logic [15:0] number_reg, number_next;
    limit_t      low_limit_reg, low_limit_next;
    limit_t      high_limit_reg, high_limit_next;
    logic        heater_reg, heater_next;
    logic        out_valid_reg;
    logic [1:0]  message_reg, message_next;
    logic [7:0]  whole_reg, whole_next;
    logic [13:0] frac_reg, frac_next;

    logic        in_fire;
    logic        is_term;
    logic        is_blank;
    logic        is_digit;
    logic [3:0]  digit;
    logic [18:0] num_ext;
    logic [18:0] num_mac;
    logic [15:0] mag;
    limit_t      parsed;
    logic        full;
    logic [1:0]  cidx;
    limit_t      whole_s;
    logic [13:0] frac_prod;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign is_term  = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
    assign is_blank = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB)
                   || (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit    = rx_byte[3:0];
    assign num_ext  = {3'b000, number_reg};
    assign num_mac  = (num_ext << 3) + (num_ext << 1) + {15'd0, digit};
    assign full     = char_count_reg >= count_t'(3);
    assign cidx     = char_count_reg[1:0];
    assign whole_s  = limit_t'({8'd0, raw_reading[11:4]});
    assign frac_prod = {10'd0, raw_reading[3:0]} * {4'd0, FRAC_STEP};

    always_comb
    begin
        if (is_negative_reg)
        begin
            mag    = (number_reg > MAG_MAX) ? MAG_MAX : number_reg;
            parsed = limit_t'(16'd0 - mag);
        end
        else
        begin
            mag    = (number_reg > 16'd32767) ? 16'd32767 : number_reg;
            parsed = limit_t'(mag);
        end
    end

    always_comb
    begin
        char_count_next  = char_count_reg;
        starts_min_next  = starts_min_reg;
        starts_max_next  = starts_max_reg;
        value_stage_next = value_stage_reg;
        target_high_next = target_high_reg;
        parse_phase_next = parse_phase_reg;
        is_negative_next = is_negative_reg;
        number_next      = number_reg;
        low_limit_next   = low_limit_reg;
        high_limit_next  = high_limit_reg;
        heater_next      = heater_reg;
        message_next     = MSG_NONE;
        whole_next       = whole_reg;
        frac_next        = frac_reg;

        if (!action)
        begin
            if (is_term)
            begin
                if (!value_stage_reg)
                begin
                    if (full && starts_min_reg)
                    begin
                        message_next     = MSG_PROMPT_MIN;
                        target_high_next = 1'b0;
                    end
                    else if (full && starts_max_reg)
                    begin
                        message_next     = MSG_PROMPT_MAX;
                        target_high_next = 1'b1;
                    end
                    else
                    begin
                        message_next = MSG_BAD_CMD;
                    end
                    value_stage_next = 1'b1;
                end
                else
                begin
                    if (target_high_reg)
                    begin
                        high_limit_next = parsed;
                    end
                    else
                    begin
                        low_limit_next = parsed;
                    end
                    value_stage_next = 1'b0;
                end
                char_count_next  = '0;
                starts_min_next  = 1'b1;
                starts_max_next  = 1'b1;
                parse_phase_next = PH_SKIP;
                is_negative_next = 1'b0;
                number_next      = '0;
            end
            else if (char_count_reg < count_t'(LINE_MAX - 1))
            begin
                if (!full)
                begin
                    if (rx_byte != cmd_min_char(cidx))
                    begin
                        starts_min_next = 1'b0;
                    end
                    if (rx_byte != cmd_max_char(cidx))
                    begin
                        starts_max_next = 1'b0;
                    end
                end
                if (parse_phase_reg == PH_SKIP)
                begin
                    if (is_blank)
                    begin
                        parse_phase_next = PH_SKIP;
                    end
                    else if ((rx_byte == CHAR_MINUS) || (rx_byte == CHAR_PLUS))
                    begin
                        is_negative_next = (rx_byte == CHAR_MINUS);
                        parse_phase_next = PH_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        number_next      = {12'd0, digit};
                        parse_phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        parse_phase_next = PH_DONE;
                    end
                end
                else if (parse_phase_reg == PH_DIGITS)
                begin
                    if (is_digit)
                    begin
                        number_next = (num_mac > {3'b000, MAG_MAX}) ? MAG_MAX
                                                                   : num_mac[15:0];
                    end
                    else
                    begin
                        parse_phase_next = PH_DONE;
                    end
                end
                char_count_next = char_count_reg + count_t'(1);
            end
        end
        else
        begin
            whole_next = raw_reading[11:4];
            frac_next  = frac_prod;
            if (whole_s >= high_limit_reg)
            begin
                heater_next = 1'b0;
            end
            else if (whole_s < low_limit_reg)
            begin
                heater_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg  <= '0;
            starts_min_reg  <= 1'b1;
            starts_max_reg  <= 1'b1;
            value_stage_reg <= 1'b0;
            target_high_reg <= 1'b0;
            parse_phase_reg <= PH_SKIP;
            is_negative_reg <= 1'b0;
            number_reg      <= '0;
            low_limit_reg   <= limit_t'(LOW_LIMIT_INIT);
            high_limit_reg  <= limit_t'(HIGH_LIMIT_INIT);
            heater_reg      <= 1'b0;
            whole_reg       <= '0;
            frac_reg        <= '0;
            out_valid_reg   <= 1'b0;
            message_reg     <= MSG_NONE;
        end
        else
        begin
            if (in_fire)
            begin
                char_count_reg  <= char_count_next;
                starts_min_reg  <= starts_min_next;
                starts_max_reg  <= starts_max_next;
                value_stage_reg <= value_stage_next;
                target_high_reg <= target_high_next;
                parse_phase_reg <= parse_phase_next;
                is_negative_reg <= is_negative_next;
                number_reg      <= number_next;
                low_limit_reg   <= low_limit_next;
                high_limit_reg  <= high_limit_next;
                heater_reg      <= heater_next;
                whole_reg       <= whole_next;
                frac_reg        <= frac_next;
                message_reg     <= message_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign message         = message_reg;
    assign heater_on       = heater_reg;
    assign whole_degrees   = whole_reg;
    assign fraction_digits = frac_reg;
    assign low_limit_now   = low_limit_reg;
    assign high_limit_now  = high_limit_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= count_t'(LINE_MAX - 1))
        else $error("line count past buffer length");

    a_stage_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !action && is_term) |=> (value_stage_reg != $past(value_stage_reg)))
        else $error("line end did not change stage");

    a_prompt_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (message_reg != MSG_NONE)) |-> value_stage_reg)
        else $error("command reply while not in value stage");

    a_limits_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(low_limit_reg) && $stable(high_limit_reg)))
        else $error("limit changed without a beat");

    a_heater_off: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action && (whole_s >= high_limit_reg)) |=> !heater_reg)
        else $error("heater not off at upper limit");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial-set thermostat.
// ----------------------------------------------------------------------------
// Serial text lines and raw sensor words go in on the input channel while
// the result channel is drained with random stalls. A predictor kept in this
// bench tracks the line state, number parsing, limits and heater switching,
// and each result beat is compared field by field with the oldest prediction.
// A short directed run covers the reading extremes, a short command, number
// overflow, crossed limits and a value line without digits. Random command
// and value lines, long lines, noise and readings follow.
// ----------------------------------------------------------------------------
module tb;
    import sst_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_BEATS = 950;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          MAX_PRINTS   = 50;
    localparam logic [23:0] MIN_WORD     = "min";
    localparam logic [23:0] MAX_WORD     = "max";

    typedef struct {
        logic        action;
        logic [7:0]  rx_byte;
        logic [15:0] raw_reading;
        int          gap;
        bit          drain;
    } beat_t;

    typedef struct packed {
        logic [1:0]  message;
        logic        heater;
        logic [7:0]  whole;
        logic [13:0] frac;
        logic [15:0] low;
        logic [15:0] high;
    } readout_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        action      = 1'b0;
    logic [7:0]  rx_byte     = '0;
    logic [15:0] raw_reading = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  message;
    logic        heater_on;
    logic [7:0]  whole_degrees;
    logic [13:0] fraction_digits;
    logic [15:0] low_limit_now;
    logic [15:0] high_limit_now;

    beat_t       beat_q[$];
    readout_t    readout_q[$];
    int          idle_cnt    = 0;
    int          ready_wait  = 0;
    int          rd_mode     = 0;
    int          results_cnt = 0;
    int          err_cnt     = 0;
    int          cycle_cnt   = 0;
    int          beats_made  = 0;
    int          gap_mode    = 0;
    bit          mix_readings = 1'b0;

    // predicted block state
    int          txt_count     = 0;
    bit          txt_min_ok    = 1'b1;
    bit          txt_max_ok    = 1'b1;
    bit          in_value_line = 1'b0;
    bit          aim_high      = 1'b0;
    logic [1:0]  num_phase     = PH_SKIP;
    bit          num_neg       = 1'b0;
    int          num_mag       = 0;
    limit_t      lim_low       = LOW_LIMIT_INIT;
    limit_t      lim_high      = HIGH_LIMIT_INIT;
    bit          heat          = 1'b0;
    logic [7:0]  temp_whole    = '0;
    logic [3:0]  temp_frac     = '0;

    serial_set_thermostat DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .rx_byte         (rx_byte),
        .raw_reading     (raw_reading),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .message         (message),
        .heater_on       (heater_on),
        .whole_degrees   (whole_degrees),
        .fraction_digits (fraction_digits),
        .low_limit_now   (low_limit_now),
        .high_limit_now  (high_limit_now)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int draw_wait(input int mode);
        int w;
        case (mode)
            0:       w = 0;
            1:       w = $urandom_range(0, 16);
            default: w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        endcase
        return w;
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= CHAR_ZERO && ch <= CHAR_NINE;
    endfunction

    function automatic readout_t thermo_predict(input logic act, input logic [7:0] ch,
                                                input logic [15:0] raw);
        readout_t r;
        int       val;
        int       whole_int;
        r.message = MSG_NONE;
        if (!act)
        begin
            if (ch == CHAR_LF || ch == CHAR_CR)
            begin
                if (!in_value_line)
                begin
                    if (txt_count >= 3 && txt_min_ok)
                    begin
                        r.message = MSG_PROMPT_MIN;
                        aim_high  = 1'b0;
                    end
                    else if (txt_count >= 3 && txt_max_ok)
                    begin
                        r.message = MSG_PROMPT_MAX;
                        aim_high  = 1'b1;
                    end
                    else
                        r.message = MSG_BAD_CMD;
                    in_value_line = 1'b1;
                end
                else
                begin
                    if (num_neg)
                        val = -((num_mag > 32768) ? 32768 : num_mag);
                    else
                        val = (num_mag > 32767) ? 32767 : num_mag;
                    if (aim_high)
                        lim_high = limit_t'(val);
                    else
                        lim_low = limit_t'(val);
                    in_value_line = 1'b0;
                end
                txt_count  = 0;
                txt_min_ok = 1'b1;
                txt_max_ok = 1'b1;
                num_phase  = PH_SKIP;
                num_neg    = 1'b0;
                num_mag    = 0;
            end
            else if (txt_count < LINE_MAX - 1)
            begin
                if (txt_count < 3)
                begin
                    if (ch != MIN_WORD[23 - 8 * txt_count -: 8])
                        txt_min_ok = 1'b0;
                    if (ch != MAX_WORD[23 - 8 * txt_count -: 8])
                        txt_max_ok = 1'b0;
                end
                if (num_phase == PH_SKIP)
                begin
                    if (ch == CHAR_MINUS || ch == CHAR_PLUS)
                    begin
                        num_neg   = (ch == CHAR_MINUS);
                        num_phase = PH_DIGITS;
                    end
                    else if (is_digit(ch))
                    begin
                        num_mag   = ch - CHAR_ZERO;
                        num_phase = PH_DIGITS;
                    end
                    else if (!(ch == CHAR_SPACE || ch == CHAR_TAB ||
                               ch == CHAR_VT || ch == CHAR_FF))
                        num_phase = PH_DONE;
                end
                else if (num_phase == PH_DIGITS)
                begin
                    if (is_digit(ch))
                    begin
                        num_mag = num_mag * 10 + (ch - CHAR_ZERO);
                        if (num_mag > 32768)
                            num_mag = 32768;
                    end
                    else
                        num_phase = PH_DONE;
                end
                txt_count++;
            end
        end
        else
        begin
            temp_whole = raw[11:4];
            temp_frac  = raw[3:0];
            whole_int  = temp_whole;
            if (whole_int >= int'(lim_high))
                heat = 1'b0;
            else if (whole_int < int'(lim_low))
                heat = 1'b1;
        end
        r.heater = heat;
        r.whole  = temp_whole;
        r.frac   = temp_frac * 14'd625;
        r.low    = lim_low;
        r.high   = lim_high;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        if (err_cnt < MAX_PRINTS)
            $display("[%0t] error: %s", $time, msg);
        err_cnt++;
    endtask

    // stimulus building
    task automatic add_beat(input logic act, input logic [7:0] ch, input logic [15:0] raw);
        beat_t nb;
        if (beats_made % 40 == 0)
            gap_mode = $urandom_range(0, 2);
        nb.action      = act;
        nb.rx_byte     = ch;
        nb.raw_reading = raw;
        nb.gap         = draw_wait(gap_mode);
        nb.drain       = (beats_made % 150 == 25);
        beat_q.push_back(nb);
        beats_made++;
    endtask

    task automatic add_reading();
        logic [15:0] raw;
        raw = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
            raw[11:4] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40))
                                                   : 8'($urandom_range(0, 255));
        add_beat(1'b1, 8'($urandom), raw);
    endtask

    task automatic add_char(input logic [7:0] ch);
        if (mix_readings && $urandom_range(0, 15) == 0)
            add_reading();
        add_beat(1'b0, ch, 16'($urandom));
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_end_of_line();
        add_char(($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF);
    endtask

    task automatic add_value_line();
        logic [7:0] blank_set [4];
        int         mag;
        int         kind;
        blank_set = '{CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
        kind = $urandom_range(0, 9);
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            add_char(blank_set[$urandom_range(0, 3)]);
        case ($urandom_range(0, 3))
            0:       add_char(CHAR_MINUS);
            1:       add_char(CHAR_PLUS);
            default: ;
        endcase
        case (kind)
            0, 1, 2, 3, 4, 5: mag = $urandom_range(0, 255);
            6:                mag = $urandom_range(256, 99999999);
            7:                mag = 32766 + $urandom_range(0, 3);
            default:          mag = -1;
        endcase
        if (mag >= 0)
            add_text($sformatf("%0d", mag));
        else if (kind == 8)
            add_text($sformatf("%03d", $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0)
            add_char(8'($urandom_range(8'h21, 8'h7E)));
        add_end_of_line();
    endtask

    task automatic add_command_line();
        add_text(($urandom_range(0, 1) == 0) ? "min" : "max");
        if ($urandom_range(0, 4) == 0)
            add_text("imum");
        add_end_of_line();
    endtask

    task automatic add_broken_command();
        case ($urandom_range(0, 6))
            0: add_text("mi");
            1: add_text("m");
            2: add_text("mix");
            3: add_text("Max");
            4: add_text("ma");
            5: add_text(" min");
            default: repeat ($urandom_range(1, 5))
                add_char(8'($urandom_range(8'h61, 8'h7A)));
        endcase
        add_end_of_line();
    endtask

    // beat driver
    always @(posedge clk)
    begin : beat_driver
        beat_t nb;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (beat_q.size() == 0)
                in_valid <= 1'b0;
            else if (idle_cnt < beat_q[0].gap ||
                     (beat_q[0].drain &&
                      (in_valid || out_valid || readout_q.size() != 0)))
            begin
                in_valid <= 1'b0;
                idle_cnt <= idle_cnt + 1;
            end
            else
            begin
                nb = beat_q.pop_front();
                in_valid    <= 1'b1;
                action      <= nb.action;
                rx_byte     <= nb.rx_byte;
                raw_reading <= nb.raw_reading;
                idle_cnt    <= 0;
            end
        end
    end

    // result monitor, predictor update and output stalls
    always @(posedge clk)
    begin : result_monitor
        readout_t got;
        readout_t want;
        int       stall;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {message, heater_on, whole_degrees, fraction_digits,
                       low_limit_now, high_limit_now};
                if (readout_q.size() == 0)
                    flag_error("result beat with nothing expected");
                else
                begin
                    want = readout_q.pop_front();
                    if (got.message !== want.message)
                        flag_error($sformatf("message got %0d want %0d",
                                             got.message, want.message));
                    if (got.heater !== want.heater)
                        flag_error($sformatf("heater_on got %0b want %0b",
                                             got.heater, want.heater));
                    if (got.whole !== want.whole)
                        flag_error($sformatf("whole_degrees got %0d want %0d",
                                             got.whole, want.whole));
                    if (got.frac !== want.frac)
                        flag_error($sformatf("fraction_digits got %0d want %0d",
                                             got.frac, want.frac));
                    if (got.low !== want.low)
                        flag_error($sformatf("low_limit_now got %0d want %0d",
                                             $signed(got.low), $signed(want.low)));
                    if (got.high !== want.high)
                        flag_error($sformatf("high_limit_now got %0d want %0d",
                                             $signed(got.high), $signed(want.high)));
                end
                results_cnt++;
                if (results_cnt % 50 == 0)
                    rd_mode = $urandom_range(0, 2);
                stall = draw_wait(rd_mode);
                out_ready  <= (stall == 0);
                ready_wait <= stall;
            end
            else if (!out_ready)
            begin
                if (ready_wait <= 1)
                    out_ready <= 1'b1;
                ready_wait <= ready_wait - 1;
            end
            if (in_valid && in_ready)
                readout_q.push_back(thermo_predict(action, rx_byte, raw_reading));
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int goal;
        int pick;

        // directed: reading extremes, heater stays off then turns on
        add_beat(1'b1, 8'hFF, 16'hFFFF);
        add_beat(1'b1, 8'h00, 16'h0000);
        // short command is bad, value still lands in the lower limit
        add_text("mi");
        add_char(CHAR_LF);
        // leading blank, plus sign, overflow clamp; limits end up crossed
        add_char(CHAR_VT);
        add_text("+99999");
        add_char(CHAR_LF);
        // off test wins over on test when crossed
        add_beat(1'b1, 8'h5A, 16'h0640);
        // sign with no digits gives zero
        add_text("max");
        add_char(CHAR_CR);
        add_char(CHAR_MINUS);
        add_text("x");
        add_char(CHAR_LF);

        mix_readings = 1'b1;
        goal = beats_made + RANDOM_BEATS;
        while (beats_made < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                add_command_line();
                add_value_line();
            end
            else if (pick < 65)
                add_reading();
            else if (pick < 75)
            begin
                add_broken_command();
                if ($urandom_range(0, 3) != 0)
                    add_value_line();
            end
            else if (pick < 82)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_text(($urandom_range(0, 1) == 0) ? "min" : "max");
                repeat ($urandom_range(14, 24))
                    add_char(8'($urandom_range(8'h20, 8'h7E)));
                add_end_of_line();
            end
            else if (pick < 90)
                repeat ($urandom_range(1, 6))
                    add_beat(1'b0, 8'($urandom), 16'($urandom));
            else if (pick < 95)
                add_end_of_line();
            else
                add_value_line();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (beat_q.size() != 0 || in_valid || readout_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
